/* rtl/core/ssr_pkg.sv */
// Shared types, constants and helpers of the stream substring replace unit.
// Used by ssr_ctrl, ssr_datapath, the top level and its checker; no dependencies.
`default_nettype none

package ssr_pkg;

   localparam int unsigned MaxPatternDefault = 8;
   localparam int unsigned ByteW             = 8;
   localparam int unsigned LenW              = 4;
   localparam int unsigned CsrAddrW          = 2;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_FIND_PATTERN   = 2'd0,
      CSR_FIND_LENGTH    = 2'd1,
      CSR_REPLACEMENT    = 2'd2,
      CSR_REPLACE_LENGTH = 2'd3
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // take the new item and load the emit buffer
      logic move;   // move the next emit buffer byte into the output register
      logic last;   // the byte being moved is the last one of its item
   } ssr_cmd_type;

   // A length of zero acts as one, anything above the maximum as the maximum.
   function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] len,
                                                 input logic [LenW-1:0] max_len);
      logic [LenW-1:0] res;
      if (len == '0) begin
         res = LenW'(1);
      end else if (len > max_len) begin
         res = max_len;
      end else begin
         res = len;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ssr_ctrl.sv */
// Controller of the stream substring replace unit: emit sequencing and handshakes.
// Depends on ssr_pkg; drives the commands of ssr_datapath.
`default_nettype none

module ssr_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic [ssr_pkg::LenW-1:0]  emit_count,
   output ssr_pkg::ssr_cmd_type           cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [ssr_pkg::LenW-1:0]   remain_ff, remain_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       slot_free;
   logic                       move;
   logic                       last;
   logic                       ready;
   logic                       load;

   always_comb begin
      slot_free = !rsp_valid_ff || rsp_tready;
      move      = (state_ff == ST_EMIT) && slot_free;
      last      = (remain_ff == ssr_pkg::LenW'(1));
      // The buffer may be reloaded in the cycle its last byte leaves.
      ready     = (state_ff == ST_IDLE) || (last && slot_free);
      load      = req_tvalid && ready;

      priority if (load) begin
         remain_in = emit_count;
      end else if (move) begin
         remain_in = remain_ff - ssr_pkg::LenW'(1);
      end else begin
         remain_in = remain_ff;
      end
      state_in     = (remain_in != '0) ? ST_EMIT : ST_IDLE;
      rsp_valid_in = move || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign cmd.load   = load;
   assign cmd.move   = move;
   assign cmd.last   = last;

endmodule

`default_nettype wire

/* rtl/core/ssr_datapath.sv */
// Datapath of the stream substring replace unit: settings, window, match and emit buffer.
// Depends on ssr_pkg; commanded by ssr_ctrl.
`default_nettype none

module ssr_datapath #(
   parameter  int unsigned MAX_PATTERN = ssr_pkg::MaxPatternDefault,
   localparam int unsigned WinW        = MAX_PATTERN * ssr_pkg::ByteW
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [ssr_pkg::CsrAddrW-1:0]  csr_addr,
   input  wire logic [WinW-1:0]               csr_wdata,
   input  wire logic [ssr_pkg::ByteW-1:0]     req_tdata,
   input  wire logic                          req_tlast,
   input  wire ssr_pkg::ssr_cmd_type          cmd,
   output logic [ssr_pkg::LenW-1:0]           emit_count,
   output logic [ssr_pkg::ByteW-1:0]          rsp_tdata,
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int unsigned BW        = ssr_pkg::ByteW;
   localparam int unsigned LW        = ssr_pkg::LenW;
   localparam int unsigned PendBytes = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
   localparam int unsigned PendW     = PendBytes * BW;
   localparam int unsigned PcW       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [WinW-1:0]   find_pattern_ff;
   logic [LW-1:0]     find_length_ff;
   logic [WinW-1:0]   replacement_ff;
   logic [LW-1:0]     replace_length_ff;

   logic [PendW-1:0]  pend_ff, pend_in;
   logic [PcW-1:0]    pend_cnt_ff, pend_cnt_in;
   logic [WinW-1:0]   emit_buf_ff, emit_buf_in;
   logic              emit_eos_ff, emit_eos_in;
   logic [BW-1:0]     out_byte_ff;
   logic              step_end_ff;
   logic              done_ff;

   logic [LW-1:0]     max_len;
   logic [LW-1:0]     lf;
   logic [LW-1:0]     lr;
   logic [LW-1:0]     cnt;
   logic [LW-1:0]     w;
   logic [WinW-1:0]   pend_wide;
   logic [WinW-1:0]   win;
   logic [WinW-1:0]   win_rest;
   logic              hit;
   logic              is_match;
   logic [LW-1:0]     start;
   logic [LW-1:0]     keep;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         find_pattern_ff   <= '0;
         find_length_ff    <= LW'(1);
         replacement_ff    <= '0;
         replace_length_ff <= LW'(1);
      end else if (csr_wr_en) begin
         unique case (ssr_pkg::csr_index_type'(csr_addr))
            ssr_pkg::CSR_FIND_PATTERN:   find_pattern_ff   <= csr_wdata;
            ssr_pkg::CSR_FIND_LENGTH:    find_length_ff    <= csr_wdata[LW-1:0];
            ssr_pkg::CSR_REPLACEMENT:    replacement_ff    <= csr_wdata;
            ssr_pkg::CSR_REPLACE_LENGTH: replace_length_ff <= csr_wdata[LW-1:0];
         endcase
      end
   end

   // Window assembly, match test and the plan for the accepted item.
   always_comb begin
      max_len   = LW'(MAX_PATTERN);
      lf        = ssr_pkg::clamp_len(find_length_ff, max_len);
      lr        = ssr_pkg::clamp_len(replace_length_ff, max_len);
      cnt       = LW'(pend_cnt_ff);
      w         = cnt + LW'(1);
      pend_wide = WinW'(pend_ff);

      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (LW'(i) < cnt) begin
            win[i*BW +: BW] = pend_wide[i*BW +: BW];
         end else if (LW'(i) == cnt) begin
            win[i*BW +: BW] = req_tdata;
         end else begin
            win[i*BW +: BW] = '0;
         end
      end

      hit = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((LW'(i) < lf) && (win[i*BW +: BW] != find_pattern_ff[i*BW +: BW])) begin
            hit = 1'b0;
         end
      end

      // A window that outgrew a shortened pattern drains without a match test.
      priority if (w > lf) begin
         start = w - lf + LW'(1);
      end else if (w == lf) begin
         start = hit ? w : LW'(1);
      end else begin
         start = '0;
      end
      is_match = (w == lf) && hit;

      // Outside a match the emitted bytes are always a prefix of the window.
      emit_count = is_match ? lr : (req_tlast ? w : start);
      keep       = (is_match || req_tlast) ? w : start;
      win_rest   = win >> {keep, 3'b000};

      pend_in     = win_rest[PendW-1:0];
      pend_cnt_in = PcW'(w - keep);
      emit_buf_in = is_match ? replacement_ff : win;
      emit_eos_in = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= '0;
      end else if (cmd.load) begin
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pend_ff     <= pend_in;
         emit_buf_ff <= emit_buf_in;
         emit_eos_ff <= emit_eos_in;
      end else if (cmd.move) begin
         emit_buf_ff <= emit_buf_ff >> BW;
      end
      if (cmd.move) begin
         out_byte_ff <= emit_buf_ff[BW-1:0];
         step_end_ff <= cmd.last;
         done_ff     <= cmd.last && emit_eos_ff;
      end
   end

   assign rsp_tdata = out_byte_ff;
   assign rsp_tuser = step_end_ff;
   assign rsp_tlast = done_ff;

endmodule

`default_nettype wire

/* rtl/core/stream_substring_replace_unit.sv */
// Top level of the stream substring replace unit.
// Depends on ssr_pkg, ssr_ctrl and ssr_datapath.
//
// The unit rewrites a byte stream, replacing every leftmost, non-overlapping
// occurrence of a search pattern with a replacement text. Scanning resumes
// after each match, never inside the inserted text.
// The request channel (req_) carries one text byte per item, with req_tlast on
// the final byte of the text. The response channel (rsp_) carries one output
// byte per item; rsp_tuser marks the last byte caused by an input item and
// rsp_tlast marks the final byte of the whole output stream.
// The csr_ port writes the pattern, its length, the replacement and its length;
// the user must do so only while the unit is idle; the unit does not check it.
// Lengths of zero act as one, larger ones as the maximum. An item's bytes drain
// from the emit buffer into the output register one byte per cycle while it is
// free; an item that emits one byte thus sustains one item per cycle when the
// receiver does not stall. The first byte of an item passes the controller
// state and the output register before it is offered. When idle, a new item is
// accepted even while the output register holds a byte the receiver has not
// taken. When the receiver stalls, the output register holds its byte and the
// emit buffer waits behind it. Reset clears the window, the emit buffer state
// and the settings (pattern and replacement zero, both lengths one).
`default_nettype none

module stream_substring_replace_unit #(
   parameter  int unsigned MAX_PATTERN = ssr_pkg::MaxPatternDefault,
   localparam int unsigned WinW        = MAX_PATTERN * ssr_pkg::ByteW
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [ssr_pkg::CsrAddrW-1:0]  csr_addr,
   input  wire logic [WinW-1:0]               csr_wdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [ssr_pkg::ByteW-1:0]     req_tdata,   // data_byte
   input  wire logic                          req_tlast,   // end_of_stream
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [ssr_pkg::ByteW-1:0]          rsp_tdata,   // out_byte
   output logic                               rsp_tuser,   // end_of_step
   output logic                               rsp_tlast    // stream_done
);

   ssr_pkg::ssr_cmd_type         cmd;
   logic [ssr_pkg::LenW-1:0]     emit_count;

   ssr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .emit_count (emit_count),
      .cmd        (cmd)
   );

   ssr_datapath #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .emit_count (emit_count),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* rtl/core/ssr_checker.sv */
// Port-level checker of the stream substring replace unit, bound to the top level.
// Depends on ssr_pkg and stream_substring_replace_unit.
`default_nettype none

module ssr_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic                       req_tlast,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [ssr_pkg::ByteW-1:0]  rsp_tdata,
   input wire logic                       rsp_tuser,
   input wire logic                       rsp_tlast
);

   // A stalled output item stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // The end of the output stream is always the end of an input item's output.
   a_done_is_step_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("stream end without step end");

   // After the final input byte is accepted, an output item is always offered.
   a_eos_emits: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> ##1 rsp_tvalid)
      else $error("no output after the final input byte");

   // Nothing is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind stream_substring_replace_unit ssr_checker u_ssr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
